>>> rtl/core/refclk_ramp_sequencer_macros.svh
// assertion macros for the reference clock ramp sequencer checker
`ifndef REFCLK_RAMP_SEQUENCER_MACROS_SVH
`define REFCLK_RAMP_SEQUENCER_MACROS_SVH

// clocked property, ignored while reset is high
`define RRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that is also checked during reset
`define RRS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rrs_pkg.sv
// shared types, codes and tables of the reference clock ramp sequencer
package rrs_pkg;

  // request actions (selector field)
  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_STEP = 2'd1,
    ACT_SYNC = 2'd2
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_AT_GOAL = 2'd2,
    ST_SYNCED  = 2'd3
  } status_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MIN_KHZ     = 3'd0;
  localparam logic [2:0] REG_MAX_KHZ     = 3'd1;
  localparam logic [2:0] REG_STEP_UP     = 3'd2;
  localparam logic [2:0] REG_STEP_DOWN   = 3'd3;
  localparam logic [2:0] REG_UP_SPAN     = 3'd4;
  localparam logic [2:0] REG_DOWN_SPAN   = 3'd5;

  // reset values
  localparam logic [17:0] MIN_KHZ_RST   = 18'd96000;
  localparam logic [17:0] MAX_KHZ_RST   = 18'd151000;
  localparam logic [11:0] STEP_UP_RST   = 12'd125;
  localparam logic [11:0] STEP_DOWN_RST = 12'd250;
  localparam logic [15:0] UP_SPAN_RST   = 16'd1000;
  localparam logic [15:0] DOWN_SPAN_RST = 16'd2000;
  localparam logic [18:0] FREQ_RST_KHZ  = 19'd100000;

  // base of the generator offset field, in MHz
  localparam logic [8:0] BASE_MHZ = 9'd100;

  // reciprocal of 1000 scaled by 2^29, rounded up
  localparam logic [19:0] RECIP_1000 = 20'd536871;
  localparam int         RECIP_SHIFT = 29;

  // kHz value of a sixteenths code, rounded as the register decode does;
  // the same values are the thresholds of the sixteenths encode
  function automatic logic [9:0] frac_khz(input logic [3:0] code);
    logic [9:0] v;
    case (code)
      4'd0:    v = 10'd0;
      4'd1:    v = 10'd63;
      4'd2:    v = 10'd125;
      4'd3:    v = 10'd188;
      4'd4:    v = 10'd250;
      4'd5:    v = 10'd313;
      4'd6:    v = 10'd375;
      4'd7:    v = 10'd438;
      4'd8:    v = 10'd500;
      4'd9:    v = 10'd563;
      4'd10:   v = 10'd625;
      4'd11:   v = 10'd688;
      4'd12:   v = 10'd750;
      4'd13:   v = 10'd813;
      4'd14:   v = 10'd875;
      4'd15:   v = 10'd938;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  // decode a clock control word (offset in bits 11:4, sixteenths in 28:25)
  function automatic logic [18:0] decode_word(input logic [31:0] w);
    logic [7:0]  off;
    logic [8:0]  mhz;
    logic [18:0] m19;
    logic [18:0] khz;
    off = w[11:4];
    mhz = {1'b0, off} + BASE_MHZ - (off[2] ? 9'd8 : 9'd0);
    m19 = 19'(mhz);
    // mhz * 1000 as 1024 - 16 - 8
    khz = (m19 << 10) - (m19 << 4) - (m19 << 3) + 19'(frac_khz(w[28:25]));
    return khz;
  endfunction

endpackage

>>> rtl/core/refclk_ramp_sequencer.sv
// reference clock ramp sequencer: target check, ramp steps and register sync
//
// requests enter on the s_ stream: tuser carries the action (set target,
// ramp step, sync from a register word), tdata the target and register word.
// each request gives exactly one result on the m_ stream: tuser carries the
// status, tdata the new frequency with its generator offset and sixteenths
// fields, the long pause flag and the ramp done flag.
// the ramp state (current, goal, pause anchor) is updated as a request moves
// from stage a to stage b, in the cycle after it is taken unless stage b is
// held, so one request per cycle is sustained while results are taken. the kHz to MHz
// split runs in two more registered stages (reciprocal multiply, then
// remainder and sixteenths compare) that do not feed back into the state.
// each stage holds its item while the next one is full, so a stalled
// receiver fills the pipe before s_tready drops; bubbles are squeezed out.
// limits, step sizes and pause spans sit on an apb port (pready always high)
// and must be written only while the block is idle, which the block itself does not enforce.
// reset clears the pipe and returns current, goal and anchor to 100 MHz and
// the registers to their defaults.
module refclk_ramp_sequencer import rrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // target_khz[17:0], reg_word[49:18], zero pad
  input  logic [1:0]  s_tuser,   // action[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // refclk_khz[18:0], offset_field[26:19],
                                 // frac_field[30:27], long_pause[31],
                                 // ramp_done[32], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [17:0] min_khz;
  logic [17:0] max_khz;
  logic [11:0] step_up_khz;
  logic [11:0] step_down_khz;
  logic [15:0] up_span_khz;
  logic [15:0] down_span_khz;

  // ramp state
  logic [18:0] current_khz;
  logic [17:0] goal_khz;
  logic [18:0] anchor_khz;
  logic [18:0] current_khz_next;
  logic [17:0] goal_khz_next;
  logic [18:0] anchor_khz_next;

  // stage a: captured request
  logic        a_valid;
  logic [1:0]  a_action;
  logic [17:0] a_target;
  logic [31:0] a_word;

  // stage b: state result
  logic        b_valid;
  status_t     b_status;
  logic [18:0] b_khz;
  logic        b_pause;
  logic        b_done;

  // stage c: quotient by 1000
  logic        c_valid;
  status_t     c_status;
  logic [18:0] c_khz;
  logic [9:0]  c_mhz;
  logic        c_pause;
  logic        c_done;

  // flow control, each stage moves when the next one is free
  logic d_free;
  logic c_free;
  logic b_free;
  logic s_take;

  assign d_free   = !m_tvalid || m_tready;
  assign c_free   = !c_valid || d_free;
  assign b_free   = !b_valid || c_free;
  assign s_tready = !a_valid || b_free;
  assign s_take   = s_tvalid && s_tready;

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_khz       <= MIN_KHZ_RST;
      max_khz       <= MAX_KHZ_RST;
      step_up_khz   <= STEP_UP_RST;
      step_down_khz <= STEP_DOWN_RST;
      up_span_khz   <= UP_SPAN_RST;
      down_span_khz <= DOWN_SPAN_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MIN_KHZ:   min_khz       <= pwdata[17:0];
        REG_MAX_KHZ:   max_khz       <= pwdata[17:0];
        REG_STEP_UP:   step_up_khz   <= pwdata[11:0];
        REG_STEP_DOWN: step_down_khz <= pwdata[11:0];
        REG_UP_SPAN:   up_span_khz   <= pwdata[15:0];
        REG_DOWN_SPAN: down_span_khz <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MIN_KHZ:   prdata = 32'(min_khz);
      REG_MAX_KHZ:   prdata = 32'(max_khz);
      REG_STEP_UP:   prdata = 32'(step_up_khz);
      REG_STEP_DOWN: prdata = 32'(step_down_khz);
      REG_UP_SPAN:   prdata = 32'(up_span_khz);
      REG_DOWN_SPAN: prdata = 32'(down_span_khz);
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------- stage a: capture request ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= s_take || (a_valid && !b_free);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      a_action <= s_tuser;
      a_target <= s_tdata[17:0];
      a_word   <= s_tdata[49:18];
    end
  end

  // ---------------- ramp state logic ----------------
  logic [19:0] up_sum;
  logic [18:0] up_khz;
  logic [19:0] up_span;
  logic        up_pause;
  logic [18:0] dn_gap;
  logic [18:0] dn_khz;
  logic [19:0] dn_span;
  logic        dn_pause;
  logic        rising;
  logic        at_goal;
  logic        in_limits;
  status_t     step_status;
  logic        step_pause;

  always_comb begin
    at_goal = (current_khz == 19'(goal_khz));
    rising  = (19'(goal_khz) > current_khz);

    // rising: clamp at the goal, pause when the rise since anchor is too big
    up_sum   = {1'b0, current_khz} + 20'(step_up_khz);
    up_khz   = (up_sum < 20'(goal_khz)) ? up_sum[18:0] : 19'(goal_khz);
    up_span  = {1'b0, up_khz} - {1'b0, anchor_khz};
    up_pause = !up_span[19] && (up_span[18:0] > 19'(up_span_khz));

    // falling: same with the down step and span
    dn_gap   = current_khz - 19'(goal_khz);
    dn_khz   = (dn_gap > 19'(step_down_khz)) ? current_khz - 19'(step_down_khz)
                                             : 19'(goal_khz);
    dn_span  = {1'b0, anchor_khz} - {1'b0, dn_khz};
    dn_pause = !dn_span[19] && (dn_span[18:0] > 19'(down_span_khz));

    in_limits = (a_target >= min_khz) && (a_target <= max_khz);

    current_khz_next = current_khz;
    goal_khz_next    = goal_khz;
    anchor_khz_next  = anchor_khz;
    step_status      = ST_REJECT;
    step_pause       = 1'b0;

    case (a_action)
      ACT_SET: begin
        if (in_limits) begin
          goal_khz_next   = a_target;
          anchor_khz_next = current_khz;
          step_status     = ST_OK;
        end
      end
      ACT_STEP: begin
        if (at_goal) begin
          step_status = ST_AT_GOAL;
        end else begin
          step_status      = ST_OK;
          current_khz_next = rising ? up_khz : dn_khz;
          step_pause       = rising ? up_pause : dn_pause;
          if (step_pause) begin
            anchor_khz_next = current_khz_next;
          end
        end
      end
      ACT_SYNC: begin
        current_khz_next = decode_word(a_word);
        step_status      = ST_SYNCED;
      end
      default: ;  // unused action: rejected, state kept
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_khz <= FREQ_RST_KHZ;
      goal_khz    <= FREQ_RST_KHZ[17:0];
      anchor_khz  <= FREQ_RST_KHZ;
    end else if (a_valid && b_free) begin
      current_khz <= current_khz_next;
      goal_khz    <= goal_khz_next;
      anchor_khz  <= anchor_khz_next;
    end
  end

  // ---------------- stage b: state result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= (a_valid && b_free) || (b_valid && !c_free);
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_status <= step_status;
      b_khz    <= current_khz_next;
      b_pause  <= step_pause;
      b_done   <= (current_khz_next == 19'(goal_khz_next));
    end
  end

  // ---------------- stage c: MHz by reciprocal multiply ----------------
  logic [38:0] recip_prod;
  assign recip_prod = 39'(b_khz) * 39'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= (b_valid && c_free) || (c_valid && !d_free);
    end
  end

  always_ff @(posedge clk) begin
    if (c_free) begin
      c_status <= b_status;
      c_khz    <= b_khz;
      c_mhz    <= recip_prod[RECIP_SHIFT +: 10];
      c_pause  <= b_pause;
      c_done   <= b_done;
    end
  end

  // ---------------- output stage: generator fields ----------------
  logic [19:0] mhz20;
  logic [19:0] mhz_khz;
  logic [9:0]  rem_khz;
  logic [7:0]  off_raw;
  logic [7:0]  off_enc;
  logic [3:0]  frac_enc;

  always_comb begin
    mhz20   = 20'(c_mhz);
    mhz_khz = (mhz20 << 10) - (mhz20 << 4) - (mhz20 << 3);
    rem_khz = 10'(20'(c_khz) - mhz_khz);

    // offset from 100 MHz with the bit 2 remap
    off_raw = c_mhz[7:0] - BASE_MHZ[7:0];
    off_enc = off_raw[2] ? off_raw + 8'd8 : off_raw;

    // sixteenths: highest code whose threshold the remainder reaches
    frac_enc = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (rem_khz >= frac_khz(4'(k))) begin
        frac_enc = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (c_valid && d_free) || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (d_free) begin
      m_tuser <= c_status;
      m_tdata <= {7'd0, c_done, c_pause, frac_enc, off_enc, c_khz};
    end
  end

endmodule

>>> rtl/core/rrs_checker.sv
// port level checks of the reference clock ramp sequencer, bound to the top level
`include "refclk_ramp_sequencer_macros.svh"

module rrs_checker import rrs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  `RRS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // a step at the goal reports done and no pause
  `RRS_ASSERT(a_at_goal, clk, rst, m_tvalid && (m_tuser == ST_AT_GOAL) |-> m_tdata[32] && !m_tdata[31], "at-goal result not done or paused")

  // only a real step may request the long pause
  `RRS_ASSERT(a_pause_step, clk, rst, m_tvalid && m_tdata[31] |-> (m_tuser == ST_OK), "long pause on a non-step result")

  // reset empties the pipe
  `RRS_ASSERT_NR(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind refclk_ramp_sequencer rrs_checker u_rrs_checker (.*);

>>> sim/refclk_ramp_sequencer_checker.sv
`timescale 1ns / 100ps
// checker for the reference clock ramp sequencer: predicts every result and compares it
module refclk_ramp_sequencer_checker import rrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // target_khz[17:0], reg_word[49:18], zero pad
  input  logic [1:0]  s_tuser,   // action[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // refclk_khz[18:0], offset_field[26:19], frac_field[30:27],
                                 // long_pause[31], ramp_done[32], zero pad
  input  logic [1:0]  m_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding
);

  typedef struct {
    status_t     status;
    logic [18:0] khz;
    logic [7:0]  offset;
    logic [3:0]  frac;
    logic        pause;
    logic        done;
  } ramp_result_t;

  logic [17:0]  lo_limit, hi_limit;
  logic [11:0]  rise_step, fall_step;
  logic [15:0]  rise_span, fall_span;
  logic [18:0]  cur_khz, anchor_khz;
  logic [17:0]  goal_khz;
  ramp_result_t expected_q[$];

  // generator offset: MHz above 100, wrapped, with the bit 2 remap
  function automatic logic [7:0] offset_code(input logic [18:0] khz);
    logic [7:0] code;
    code = 8'(khz / 19'd1000 - 19'd100);
    if (code[2]) code = code + 8'd8;
    return code;
  endfunction

  function automatic logic [3:0] sixteenths(input logic [18:0] khz);
    return 4'((int'(khz % 19'd1000) * 16) / 1000);
  endfunction

  function automatic logic [18:0] word_khz(input logic [31:0] w);
    logic [7:0] off;
    int         frac;
    int         mhz;
    off = w[11:4];
    frac = (int'(w[28:25]) * 1000 + 15) / 16;
    mhz = int'(off) + 100 - (off[2] ? 8 : 0);
    return 19'(mhz * 1000 + frac);
  endfunction

  // applies one request to the ramp state and returns the result it should give
  function automatic ramp_result_t advance_ramp(input logic [1:0] act, input logic [17:0] target,
                                                input logic [31:0] word);
    ramp_result_t r;
    int           nxt;
    int           span;
    r.status = ST_REJECT;
    r.pause = 1'b0;
    case (act)
      ACT_SET: begin
        if (target >= lo_limit && target <= hi_limit) begin
          goal_khz = target;
          anchor_khz = cur_khz;
          r.status = ST_OK;
        end
      end
      ACT_STEP: begin
        if (cur_khz == 19'(goal_khz)) begin
          r.status = ST_AT_GOAL;
        end else begin
          if (19'(goal_khz) > cur_khz) begin
            nxt = int'(cur_khz) + int'(rise_step);
            cur_khz = 19'((nxt < int'(goal_khz)) ? nxt : int'(goal_khz));
            span = int'(cur_khz) - int'(anchor_khz);
            r.pause = (span > int'(rise_span));
          end else begin
            if (int'(cur_khz) - int'(goal_khz) > int'(fall_step)) cur_khz = cur_khz - 19'(fall_step);
            else cur_khz = 19'(goal_khz);
            span = int'(anchor_khz) - int'(cur_khz);
            r.pause = (span > int'(fall_span));
          end
          if (r.pause) anchor_khz = cur_khz;
          r.status = ST_OK;
        end
      end
      ACT_SYNC: begin
        cur_khz = word_khz(word);
        r.status = ST_SYNCED;
      end
      default: ;
    endcase
    r.khz = cur_khz;
    r.offset = offset_code(cur_khz);
    r.frac = sixteenths(cur_khz);
    r.done = (cur_khz == 19'(goal_khz));
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ramp_result_t want;
    if (rst) begin
      lo_limit = MIN_KHZ_RST;
      hi_limit = MAX_KHZ_RST;
      rise_step = STEP_UP_RST;
      fall_step = STEP_DOWN_RST;
      rise_span = UP_SPAN_RST;
      fall_span = DOWN_SPAN_RST;
      cur_khz = FREQ_RST_KHZ;
      goal_khz = 18'(FREQ_RST_KHZ);
      anchor_khz = FREQ_RST_KHZ;
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MIN_KHZ:   lo_limit = pwdata[17:0];
          REG_MAX_KHZ:   hi_limit = pwdata[17:0];
          REG_STEP_UP:   rise_step = pwdata[11:0];
          REG_STEP_DOWN: fall_step = pwdata[11:0];
          REG_UP_SPAN:   rise_span = pwdata[15:0];
          REG_DOWN_SPAN: fall_span = pwdata[15:0];
          default: ;
        endcase
      end
      // results first: a result never belongs to a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual khz %0d status %0d",
                   $time, m_tdata[18:0], m_tuser);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", int'(want.status), int'(m_tuser));
          check_field("refclk_khz", int'(want.khz), int'(m_tdata[18:0]));
          check_field("offset_field", int'(want.offset), int'(m_tdata[26:19]));
          check_field("frac_field", int'(want.frac), int'(m_tdata[30:27]));
          check_field("long_pause", int'(want.pause), int'(m_tdata[31]));
          check_field("ramp_done", int'(want.done), int'(m_tdata[32]));
        end
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(advance_ramp(s_tuser, s_tdata[17:0], s_tdata[49:18]));
      outstanding <= expected_q.size();
    end
  end

endmodule

>>> sim/refclk_ramp_sequencer_test.sv
`timescale 1ns / 100ps
// top of the reference clock ramp sequencer test: clock, reset, stimulus and verdict
module refclk_ramp_sequencer_test import rrs_pkg::*; ();

  // action code the block has no meaning for
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 64;    // long receiver hold-off to fill the pipe
  localparam int STALL_LIMIT  = 1000;  // cycles with nothing moving before giving up
  localparam int DRAIN_CYCLES = 12;    // idle cycles after the last drain, before the verdict
  localparam int PHASE_ITEMS  = 225;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // target_khz[17:0], reg_word[49:18], zero pad
  logic [1:0]  s_tuser;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // refclk_khz[18:0], offset_field[26:19], frac_field[30:27],
                          // long_pause[31], ramp_done[32], zero pad
  logic [1:0]  m_tuser;   // status[1:0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int outstanding;

  // idling knobs, set by the stimulus and read by the sender and receiver
  int tx_idle_pct;
  int rx_stall_pct;
  // hold-off handshake between stimulus and receiver
  int hold_asks;
  int hold_taken;
  int hold_left;
  int quiet_cycles;

  // stimulus-side copy of the limits and step sizes, used only to aim targets
  int cfg_min;
  int cfg_max;
  int cfg_up;
  int cfg_down;
  int hint_khz;

  always #5 clk = ~clk;

  refclk_ramp_sequencer dut (.*);

  refclk_ramp_sequencer_checker ramp_check (.*);

  // one register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [2:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // writes every register back to back and keeps the aiming copy in step
  task automatic apply_config(input int lo, input int hi, input int up, input int down,
                              input int up_span, input int down_span);
    cfg_min = lo;
    cfg_max = hi;
    cfg_up = up;
    cfg_down = down;
    reg_write(REG_MIN_KHZ, lo);
    reg_write(REG_MAX_KHZ, hi);
    reg_write(REG_STEP_UP, up);
    reg_write(REG_STEP_DOWN, down);
    reg_write(REG_UP_SPAN, up_span);
    reg_write(REG_DOWN_SPAN, down_span);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // offers one request, with random idle cycles in front, and waits until it is taken
  task automatic send_request(input logic [1:0] act, input logic [17:0] target,
                              input logic [31:0] word);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {6'b0, word, target};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait until every request has its result back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // a target up to 16 steps plus 500 kHz off the last, inside the limits if they allow it
  function automatic logic [17:0] near_target();
    int reach;
    int t;
    reach = (cfg_up > cfg_down ? cfg_up : cfg_down) * $urandom_range(1, 16)
            + $urandom_range(0, 500);
    t = hint_khz + $urandom_range(0, 2 * reach) - reach;
    if ($urandom_range(0, 7) == 0) t = $urandom_range(0, 1) ? cfg_min : cfg_max;
    if (cfg_min <= cfg_max) begin
      if (t < cfg_min) t = cfg_min;
      if (t > cfg_max) t = cfg_max;
    end
    if (t < 0) t = 0;
    if (t > 262143) t = 262143;
    return 18'(t);
  endfunction

  // mostly set-then-ramp runs with random content, the rest syncs and noise
  task automatic random_phase(input int n_items);
    int          sent;
    int          k;
    int          r;
    logic [31:0] w;
    logic [17:0] t;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        t = near_target();
        hint_khz = int'(t);
        send_request(ACT_SET, t, $urandom);
        k = $urandom_range(1, 20);
        repeat (k) send_request(ACT_STEP, 18'($urandom), $urandom);
        sent += k + 1;
      end else if (r < 72) begin
        // sync words mostly land near the usual operating range
        w = $urandom;
        if ($urandom_range(0, 3) != 0) w[11:4] = 8'($urandom_range(0, 60));
        send_request(ACT_SYNC, 18'($urandom), w);
        sent++;
      end else if (r < 82) begin
        send_request(ACT_SET, 18'($urandom), $urandom);
        sent++;
      end else if (r < 92) begin
        k = $urandom_range(1, 6);
        repeat (k) send_request(ACT_STEP, 18'($urandom), $urandom);
        sent += k;
      end else if (r < 96) begin
        send_request(ACT_UNUSED, 18'($urandom), $urandom);
        sent++;
      end else begin
        // just outside one of the limits
        t = 18'($urandom_range(0, 1) ? cfg_min - 1 : cfg_max + 1);
        send_request(ACT_SET, t, $urandom);
        sent++;
      end
    end
  endtask

  // receiver: random stalls, or a long hold-off when the stimulus asks for one
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_taken != hold_asks) begin
        hold_taken = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // watchdog: nothing accepted on either stream or the register port for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("refclk_ramp_sequencer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int lo;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= ACT_SET;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_min = int'(MIN_KHZ_RST);
    cfg_max = int'(MAX_KHZ_RST);
    cfg_up = int'(STEP_UP_RST);
    cfg_down = int'(STEP_DOWN_RST);
    hint_khz = int'(FREQ_RST_KHZ);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset settings
    send_request(ACT_STEP, 18'($urandom), $urandom);      // step while already at target
    send_request(ACT_SET, 18'd95999, $urandom);           // one below the lower limit
    send_request(ACT_SET, 18'd0, $urandom);
    send_request(ACT_SET, 18'h3FFFF, $urandom);
    send_request(ACT_SET, 18'd151001, $urandom);          // one above the upper limit
    send_request(ACT_SET, 18'd96000, $urandom);           // lower limit itself
    send_request(ACT_SET, 18'd151000, $urandom);          // upper limit itself
    // climbing past the rise span asks for a long pause and moves the anchor
    repeat (10) send_request(ACT_STEP, 18'($urandom), $urandom);
    send_request(ACT_SET, 18'd100500, $urandom);
    repeat (3) send_request(ACT_STEP, 18'($urandom), $urandom);
    send_request(ACT_SYNC, 18'($urandom), 32'h0000_0000);
    send_request(ACT_SYNC, 18'($urandom), 32'hFFFF_FFFF); // largest offset, remapped
    // sync to 97 MHz below the anchor: the rise that follows is no pause
    send_request(ACT_SYNC, 18'($urandom), 32'h0000_0050);
    send_request(ACT_STEP, 18'($urandom), $urandom);
    send_request(ACT_SYNC, 18'($urandom), 32'h1E00_0000); // top sixteenths code only
    send_request(ACT_UNUSED, 18'($urandom), $urandom);
    hint_khz = 100500;

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: apply_config(96000, 151000, 125, 250, 1000, 2000);
        1: apply_config(0, 262143, 4095, 4095, 0, 0);
        2: apply_config(90000, 200000, 1, 1, 65535, 65535);
        3: apply_config(262143, 0, 700, 33, 3000, 500);      // limits crossed: every set rejected
        4: apply_config(95000, 160000, 0, 0, 0, 0);          // zero step sizes
        7: apply_config(98000, 140000, 200, 3000, 400, 2500);
        default: begin
          lo = $urandom_range(80000, 130000);
          apply_config(lo, $urandom_range(lo, 262143), $urandom_range(1, 4095),
                       $urandom_range(1, 4095), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
        end
      endcase
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
          // sender keeps offering while the receiver holds off
          hold_asks++;
        end
        1: begin
          tx_idle_pct = 53;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 53;
        end
        default: begin
          tx_idle_pct = 8;
          rx_stall_pct = 8;
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("refclk_ramp_sequencer test passed");
    else $display("refclk_ramp_sequencer test failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rrs_pkg.sv
rtl/core/refclk_ramp_sequencer.sv
rtl/core/rrs_checker.sv
sim/refclk_ramp_sequencer_checker.sv
sim/refclk_ramp_sequencer_test.sv
